// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CRBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// same, with a message of its own
`define CRBM_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

// ----- src/crbm_pkg.sv -----
// constants and types of the chunked ring buffer manager
package crbm_pkg;

  localparam int CHUNK_BYTES = 4096;
  localparam int NUM_CHUNKS  = 16;
  localparam int LEN_W       = 13;
  localparam int IDX_W       = $clog2(NUM_CHUNKS);
  localparam int OP_W        = 2;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam len_t CHUNK_LEN = len_t'(CHUNK_BYTES);
  localparam idx_t LAST_IDX  = idx_t'(NUM_CHUNKS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_GET_SPACE = 2'd0,
    OP_PUSH      = 2'd1,
    OP_GET_DATA  = 2'd2,
    OP_POP       = 2'd3
  } op_e;

  typedef struct packed {
    op_e  operation;
    len_t amount;
  } cmd_t;

  typedef struct packed {
    len_t length;
    idx_t chunk_index;
    len_t byte_offset;
    logic unavailable;
    logic clamped;
  } result_t;

endpackage

// ----- src/crbm_if.sv -----
// valid/ready channels for commands and results
interface crbm_cmd_if import crbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  len_t             amount;

  modport source (output valid, output operation, output amount, input ready);
  modport sink   (input valid, input operation, input amount, output ready);
endinterface

interface crbm_res_if import crbm_pkg::*; ();
  logic valid;
  logic ready;
  len_t length;
  idx_t chunk_index;
  len_t byte_offset;
  logic unavailable;
  logic clamped;

  modport source (output valid, output length, output chunk_index, output byte_offset,
                  output unavailable, output clamped, input ready);
  modport sink   (input valid, input length, input chunk_index, input byte_offset,
                  input unavailable, input clamped, output ready);
endinterface

// ----- src/crbm_desc.sv -----
// ring descriptor state and the per-operation update logic
`include "assert_macros.svh"

module crbm_desc import crbm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    upd_i,
  input  cmd_t    cmd_i,
  output result_t res_o
);

  // only the write chunk's fill is stored: chunks from head up to the write
  // chunk are full, chunks after it are empty
  idx_t head_q, head_d;
  idx_t write_q, write_d;
  len_t rd_off_q, rd_off_d;
  len_t wfill_q, wfill_d;

  idx_t tail;
  logic w_is_tail;
  logic h_is_w;
  len_t fill_h;
  len_t free_len;
  len_t unread;
  len_t amt_c;
  len_t sum;

  always_comb begin
    tail      = (head_q == '0) ? LAST_IDX : head_q - idx_t'(1);
    w_is_tail = (write_q == tail);
    h_is_w    = (head_q == write_q);
    fill_h    = h_is_w ? wfill_q : CHUNK_LEN;
    free_len  = CHUNK_LEN - wfill_q;
    unread    = fill_h - rd_off_q;

    head_d   = head_q;
    write_d  = write_q;
    rd_off_d = rd_off_q;
    wfill_d  = wfill_q;
    amt_c    = '0;
    sum      = '0;
    res_o    = '0;

    case (cmd_i.operation)
      OP_GET_SPACE: begin
        res_o.chunk_index = write_q;
        res_o.byte_offset = wfill_q;
        if (w_is_tail && (wfill_q == CHUNK_LEN)) begin
          res_o.unavailable = 1'b1;
        end else begin
          res_o.length = free_len;
        end
      end
      OP_PUSH: begin
        res_o.clamped = (cmd_i.amount > free_len);
        amt_c = res_o.clamped ? free_len : cmd_i.amount;
        sum   = wfill_q + amt_c;
        if ((sum == CHUNK_LEN) && !w_is_tail) begin
          // next chunk is past the write chunk, so it starts empty
          write_d = (write_q == LAST_IDX) ? '0 : write_q + idx_t'(1);
          wfill_d = '0;
        end else begin
          wfill_d = sum;
        end
      end
      OP_GET_DATA: begin
        res_o.chunk_index = head_q;
        res_o.byte_offset = rd_off_q;
        if (h_is_w && (rd_off_q == wfill_q)) begin
          res_o.unavailable = 1'b1;
        end else begin
          res_o.length = unread;
        end
      end
      OP_POP: begin
        res_o.clamped = (cmd_i.amount > unread);
        amt_c = res_o.clamped ? unread : cmd_i.amount;
        sum   = rd_off_q + amt_c;
        if ((sum == fill_h) && !h_is_w) begin
          // drained head chunk is recycled as the new tail
          head_d   = (head_q == LAST_IDX) ? '0 : head_q + idx_t'(1);
          rd_off_d = '0;
        end else begin
          rd_off_d = sum;
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      write_q  <= '0;
      rd_off_q <= '0;
      wfill_q  <= '0;
    end else if (upd_i) begin
      head_q   <= head_d;
      write_q  <= write_d;
      rd_off_q <= rd_off_d;
      wfill_q  <= wfill_d;
    end
  end

  `CRBM_ASSERT_MSG(a_wfill_bound, wfill_q <= CHUNK_LEN, "write fill beyond chunk size")
  `CRBM_ASSERT_MSG(a_rd_off_bound, rd_off_q <= fill_h, "read offset beyond head fill")
  `CRBM_ASSERT(a_write_advance_empty,
    (upd_i && (cmd_i.operation == OP_PUSH) && (write_d != write_q)) |=> (wfill_q == '0))
  `CRBM_ASSERT(a_head_advance_zero,
    (upd_i && (cmd_i.operation == OP_POP) && (head_d != head_q)) |=> (rd_off_q == '0))

endmodule

// ----- src/chunked_ring_buffer_manager_core.sv -----
// chunked ring buffer manager: command register, descriptor logic, result register
// an accepted command beat is held in the command register, its result beat in the result register
// throughput: one command per cycle while the result side takes each beat
// output stalls back up through the command register, no beat is dropped
// reset (rst_ni low, asynchronous): ring empty, head and write chunk 0, no beats held
`include "assert_macros.svh"

module chunked_ring_buffer_manager_core import crbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  crbm_cmd_if.sink   in_i,
  crbm_res_if.source out_o
);

  logic    cmd_vld_q;
  cmd_t    cmd_q;
  logic    res_vld_q;
  result_t res_q;
  result_t res_d;
  logic    advance;
  logic    upd;

  assign advance  = !res_vld_q || out_o.ready;
  assign upd      = cmd_vld_q && advance;
  assign in_i.ready = !cmd_vld_q || advance;

  crbm_desc u_desc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .cmd_i  (cmd_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        cmd_vld_q <= in_i.valid;
      end
      if (advance) begin
        res_vld_q <= cmd_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      cmd_q.operation <= op_e'(in_i.operation);
      cmd_q.amount    <= in_i.amount;
    end
    if (upd) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = res_vld_q;
  assign out_o.length      = res_q.length;
  assign out_o.chunk_index = res_q.chunk_index;
  assign out_o.byte_offset = res_q.byte_offset;
  assign out_o.unavailable = res_q.unavailable;
  assign out_o.clamped     = res_q.clamped;

  `CRBM_ASSERT_MSG(a_accept_loads, (in_i.valid && in_i.ready) |=> cmd_vld_q,
    "accepted command beat not held")
  `CRBM_ASSERT_MSG(a_upd_yields_result, upd |=> res_vld_q, "processed command gave no result")
  `CRBM_ASSERT_MSG(a_stall_blocks_input, (cmd_vld_q && res_vld_q && !out_o.ready) |-> !in_i.ready,
    "command taken while both stages stalled")

endmodule

// ----- tb/sv/tb.sv -----
// testbench for the chunked ring buffer manager: directed script, random traffic, scoreboard
`timescale 1ns / 100ps

module tb;
  import crbm_pkg::*;

  localparam int RAND_ITEMS = 1700;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE     = 8;

  typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} traffic_e;

  typedef struct {
    op_e     op;
    len_t    amt;
    int      reps;
    bit      typed;
    result_t want;
  } script_row_t;

  logic clk_i;
  logic rst_ni;

  crbm_cmd_if cmd_ch ();
  crbm_res_if res_ch ();

  chunked_ring_buffer_manager_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  // descriptor state as the block should hold it
  idx_t        ring_head;
  idx_t        ring_wr;
  int unsigned ring_rd_off;
  int unsigned ring_fill [NUM_CHUNKS];

  result_t     awaited_desc [$];
  script_row_t script [$];
  bit          steady;
  int          bad_beats = 0;
  int          idle_cycles = 0;
  result_t     want_desc;
  result_t     seen_desc;

  always #4 clk_i = ~clk_i;

  function automatic idx_t ring_next(idx_t c);
    return idx_t'((c + 1) % NUM_CHUNKS);
  endfunction

  // one operation on the descriptors, returns the result beat it causes
  function automatic result_t descriptor_update(op_e op, len_t amt_in);
    result_t     r;
    int unsigned amt;
    int unsigned room;
    idx_t        tail;
    r    = '0;
    amt  = amt_in;
    tail = idx_t'((ring_head + NUM_CHUNKS - 1) % NUM_CHUNKS);
    case (op)
      OP_GET_SPACE: begin
        r.chunk_index = ring_wr;
        r.byte_offset = len_t'(ring_fill[ring_wr]);
        if (ring_wr == tail && ring_fill[ring_wr] >= CHUNK_BYTES) r.unavailable = 1'b1;
        else r.length = len_t'(CHUNK_BYTES - ring_fill[ring_wr]);
      end
      OP_PUSH: begin
        room = (ring_fill[ring_wr] >= CHUNK_BYTES) ? 0 : CHUNK_BYTES - ring_fill[ring_wr];
        if (amt > room) begin
          amt       = room;
          r.clamped = 1'b1;
        end
        ring_fill[ring_wr] += amt;
        if (ring_fill[ring_wr] == CHUNK_BYTES && ring_wr != tail) ring_wr = ring_next(ring_wr);
      end
      OP_GET_DATA: begin
        r.chunk_index = ring_head;
        r.byte_offset = len_t'(ring_rd_off);
        if (ring_head == ring_wr && ring_rd_off == ring_fill[ring_head]) begin
          r.unavailable = 1'b1;
        end else begin
          r.length = (ring_fill[ring_head] > ring_rd_off) ?
                     len_t'(ring_fill[ring_head] - ring_rd_off) : '0;
        end
      end
      default: begin
        room = (ring_fill[ring_head] > ring_rd_off) ? ring_fill[ring_head] - ring_rd_off : 0;
        if (amt > room) begin
          amt       = room;
          r.clamped = 1'b1;
        end
        ring_rd_off += amt;
        // drained head that is no longer written becomes the new tail
        if (ring_rd_off == ring_fill[ring_head] && ring_head != ring_wr) begin
          ring_fill[ring_head] = 0;
          ring_head            = ring_next(ring_head);
          ring_rd_off          = 0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic result_t desc(int len, int idx, int off, bit unav, bit clamp);
    return {len_t'(len), idx_t'(idx), len_t'(off), unav, clamp};
  endfunction

  task automatic add_row(op_e op, int amt, int reps, bit typed, result_t want);
    script_row_t r;
    r.op    = op;
    r.amt   = len_t'(amt);
    r.reps  = reps;
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endtask

  function automatic op_e pick_op(traffic_e mix);
    int unsigned r;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  return r < 55 ? OP_PUSH : r < 65 ? OP_POP : r < 85 ? OP_GET_SPACE : OP_GET_DATA;
      MIX_DRAIN: return r < 55 ? OP_POP : r < 65 ? OP_PUSH : r < 80 ? OP_GET_SPACE : OP_GET_DATA;
      default:   return op_e'(r % 4);
    endcase
  endfunction

  function automatic len_t pick_amount(op_e op);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 35) return len_t'($urandom_range(64));
    if (sel < 65) return len_t'($urandom_range(CHUNK_BYTES));
    // exact fit of what is left in the chunk
    if (sel < 80) begin
      if (op == OP_PUSH) return len_t'(CHUNK_BYTES - ring_fill[ring_wr]);
      return len_t'(ring_fill[ring_head] - ring_rd_off);
    end
    return len_t'($urandom);
  endfunction

  task automatic issue(op_e op, len_t amt, bit typed, result_t want);
    result_t predicted;
    while (!steady && $urandom_range(99) < 12) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.amount    <= amt;
    do @(posedge clk_i); while (!cmd_ch.ready);
    predicted = descriptor_update(op, amt);
    awaited_desc.push_back(typed ? want : predicted);
  endtask

  task automatic hold_until_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_desc.size() != 0);
  endtask

  // result side: random stalls except during the steady stretch
  always @(posedge clk_i) res_ch.ready <= steady || ($urandom_range(99) >= 12);

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      seen_desc = {res_ch.length, res_ch.chunk_index, res_ch.byte_offset,
                   res_ch.unavailable, res_ch.clamped};
      if (awaited_desc.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("%0t unexpected result beat: len=%0d idx=%0d off=%0d unav=%b clamp=%b",
                   $time, seen_desc.length, seen_desc.chunk_index, seen_desc.byte_offset,
                   seen_desc.unavailable, seen_desc.clamped);
      end else begin
        want_desc = awaited_desc.pop_front();
        if (seen_desc.length !== want_desc.length ||
            seen_desc.chunk_index !== want_desc.chunk_index ||
            seen_desc.byte_offset !== want_desc.byte_offset ||
            seen_desc.unavailable !== want_desc.unavailable ||
            seen_desc.clamped !== want_desc.clamped) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("%0t mismatch: exp len=%0d idx=%0d off=%0d unav=%b clamp=%b,",
                     $time, want_desc.length, want_desc.chunk_index, want_desc.byte_offset,
                     want_desc.unavailable, want_desc.clamped,
                     " got len=%0d idx=%0d off=%0d unav=%b clamp=%b",
                     seen_desc.length, seen_desc.chunk_index, seen_desc.byte_offset,
                     seen_desc.unavailable, seen_desc.clamped);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    result_t  none;
    traffic_e mix;
    op_e      op;
    none             = '0;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    steady           = 1'b0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.operation = OP_GET_SPACE;
    cmd_ch.amount    = '0;
    ring_head        = '0;
    ring_wr          = '0;
    ring_rd_off      = 0;
    foreach (ring_fill[c]) ring_fill[c] = 0;

    // empty ring, clamps, zero amounts, full ring, drained head still being written
    add_row(OP_GET_SPACE, 0,    1,  1, desc(4096, 0, 0, 0, 0));
    add_row(OP_GET_DATA,  8191, 1,  1, desc(0, 0, 0, 1, 0));
    add_row(OP_POP,       8191, 1,  1, desc(0, 0, 0, 0, 1));
    add_row(OP_PUSH,      0,    1,  1, desc(0, 0, 0, 0, 0));
    add_row(OP_PUSH,      8191, 1,  1, desc(0, 0, 0, 0, 1));
    add_row(OP_GET_SPACE, 0,    1,  1, desc(4096, 1, 0, 0, 0));
    add_row(OP_GET_DATA,  0,    1,  1, desc(4096, 0, 0, 0, 0));
    add_row(OP_POP,       100,  1,  1, desc(0, 0, 0, 0, 0));
    add_row(OP_GET_DATA,  0,    1,  1, desc(3996, 0, 100, 0, 0));
    add_row(OP_POP,       8191, 1,  1, desc(0, 0, 0, 0, 1));
    add_row(OP_GET_DATA,  0,    1,  1, desc(0, 1, 0, 1, 0));
    add_row(OP_PUSH,      4096, 15, 0, none);
    add_row(OP_PUSH,      4095, 1,  0, none);
    add_row(OP_GET_SPACE, 0,    1,  1, desc(1, 0, 4095, 0, 0));
    add_row(OP_PUSH,      1,    1,  0, none);
    add_row(OP_GET_SPACE, 0,    1,  1, desc(0, 0, 4096, 1, 0));
    add_row(OP_PUSH,      5,    1,  1, desc(0, 0, 0, 0, 1));
    add_row(OP_PUSH,      0,    1,  0, none);
    add_row(OP_GET_DATA,  0,    1,  1, desc(4096, 1, 0, 0, 0));
    add_row(OP_POP,       0,    1,  0, none);
    add_row(OP_POP,       4096, 16, 0, none);
    add_row(OP_GET_DATA,  0,    1,  1, desc(0, 0, 4096, 1, 0));
    add_row(OP_GET_SPACE, 0,    1,  1, desc(0, 0, 4096, 0, 0));
    add_row(OP_PUSH,      0,    1,  0, none);
    add_row(OP_POP,       0,    1,  0, none);
    add_row(OP_GET_DATA,  0,    1,  1, desc(0, 1, 0, 1, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[k])
      repeat (script[k].reps) issue(script[k].op, script[k].amt, script[k].typed, script[k].want);
    hold_until_drained();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      steady = (i >= 500 && i < 800);
      if (i == 850) hold_until_drained();
      mix = traffic_e'((i / 150) % 3);
      op  = pick_op(mix);
      issue(op, pick_amount(op), 1'b0, none);
    end
    steady = 1'b0;

    hold_until_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (bad_beats == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
